// ===== hw/rtl/mvt_pkg.sv =====
// Shared constants and types for the 4x4 matrix-vector transform engine.
`default_nettype none

package mvt_pkg;

    localparam int NUM_LANES    = 4;   // one lane per matrix row
    localparam int NUM_COLS     = 4;
    localparam int FIELD_BITS   = 32;  // width of each vector field on the ports
    localparam int CFG_BITS     = 64;
    localparam int NUM_REGS     = 8;
    localparam int CFG_IDX_BITS = 3;
    localparam int LANE_STAGES  = 4;   // multiply, pair add, final add, shift/saturate

    typedef logic [CFG_IDX_BITS-1:0] t_cfg_idx;

    // Configuration register indexes
    localparam t_cfg_idx CFG_ROW0_COLS01 = 3'd0;
    localparam t_cfg_idx CFG_ROW0_COLS23 = 3'd1;
    localparam t_cfg_idx CFG_ROW1_COLS01 = 3'd2;
    localparam t_cfg_idx CFG_ROW1_COLS23 = 3'd3;
    localparam t_cfg_idx CFG_ROW2_COLS01 = 3'd4;
    localparam t_cfg_idx CFG_ROW2_COLS23 = 3'd5;
    localparam t_cfg_idx CFG_ROW3_COLS01 = 3'd6;
    localparam t_cfg_idx CFG_ROW3_COLS23 = 3'd7;

    // Merged result of all lanes, as it leaves on the output channel.
    typedef struct packed {
        logic [NUM_LANES-1:0]                 sat;
        logic [NUM_LANES-1:0][FIELD_BITS-1:0] comp;
    } t_result;

endpackage

`default_nettype wire

// ===== hw/rtl/mvt_lane.sv =====
// One row lane: four products, adder tree, arithmetic shift and saturation.
`default_nettype none

module mvt_lane
    import mvt_pkg::*;
#(
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_en,
    input  logic [NUM_COLS-1:0][WORD_BITS-1:0]  i_row,
    input  logic [NUM_COLS-1:0][WORD_BITS-1:0]  i_vec,
    output logic [WORD_BITS-1:0]                o_res,
    output logic                                o_sat
);

    localparam int PROD_BITS = 2 * WORD_BITS;
    localparam int PAIR_BITS = PROD_BITS + 1;
    localparam int SUM_BITS  = PROD_BITS + 2;
    localparam logic [WORD_BITS-1:0] MAX_VAL = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam logic [WORD_BITS-1:0] MIN_VAL = {1'b1, {(WORD_BITS-1){1'b0}}};

    logic signed [PROD_BITS-1:0] n_prod [NUM_COLS];
    logic signed [PROD_BITS-1:0] r_prod [NUM_COLS];
    logic signed [PAIR_BITS-1:0] n_sum01, n_sum23, r_sum01, r_sum23;
    logic signed [SUM_BITS-1:0]  n_sum, r_sum, w_sh;
    logic [SUM_BITS-WORD_BITS:0] w_upper;
    logic [WORD_BITS-1:0]        n_res, r_res;
    logic                        n_sat, r_sat;

    always_comb begin
        for (int c = 0; c < NUM_COLS; c++) begin
            n_prod[c] = $signed(i_row[c]) * $signed(i_vec[c]);
        end
    end

    always_comb begin
        n_sum01 = {r_prod[0][PROD_BITS-1], r_prod[0]} + {r_prod[1][PROD_BITS-1], r_prod[1]};
        n_sum23 = {r_prod[2][PROD_BITS-1], r_prod[2]} + {r_prod[3][PROD_BITS-1], r_prod[3]};
        n_sum   = {r_sum01[PAIR_BITS-1], r_sum01} + {r_sum23[PAIR_BITS-1], r_sum23};
    end

    // Floor shift; the value fits a word when all bits from the word sign up agree.
    always_comb begin
        w_sh    = r_sum >>> FRAC_BITS;
        w_upper = w_sh[SUM_BITS-1:WORD_BITS-1];
        n_sat   = !((&w_upper) || !(|w_upper));
        if (!n_sat) begin
            n_res = w_sh[WORD_BITS-1:0];
        end else if (w_sh[SUM_BITS-1]) begin
            n_res = MIN_VAL;
        end else begin
            n_res = MAX_VAL;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int c = 0; c < NUM_COLS; c++) begin
                r_prod[c] <= n_prod[c];
            end
            r_sum01 <= n_sum01;
            r_sum23 <= n_sum23;
            r_sum   <= n_sum;
            r_res   <= n_res;
            r_sat   <= n_sat;
        end
    end

    assign o_res = r_res;
    assign o_sat = r_sat;

endmodule

`default_nettype wire

// ===== hw/rtl/mvt_out.sv =====
// Merge stage: gathers the lane results into one transaction, output register and skid.
`default_nettype none

module mvt_out
    import mvt_pkg::*;
#(
    parameter int WORD_BITS = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    input  logic [NUM_LANES-1:0][WORD_BITS-1:0] i_res,
    input  logic [NUM_LANES-1:0]                i_sat,
    output logic                                o_ready,
    output logic                                o_valid,
    input  logic                                i_ready,
    output t_result                             o_data
);

    t_result w_merged;
    t_result r_out, r_skid;
    logic    r_out_v, r_skid_v;
    logic    w_take;

    always_comb begin
        for (int i = 0; i < NUM_LANES; i++) begin
            w_merged.comp[i] = FIELD_BITS'(i_res[i]);
        end
        w_merged.sat = i_sat;
    end

    assign w_take = r_out_v && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (w_take) begin
                r_out    <= r_skid;
                r_skid_v <= 1'b0;
            end
        end else if (i_valid) begin
            if (!r_out_v || w_take) begin
                r_out   <= w_merged;
                r_out_v <= 1'b1;
            end else begin
                // output still waiting: park the transaction
                r_skid   <= w_merged;
                r_skid_v <= 1'b1;
            end
        end else if (w_take) begin
            r_out_v <= 1'b0;
        end
    end

    assign o_ready = !r_skid_v;
    assign o_valid = r_out_v;
    assign o_data  = r_out;

endmodule

`default_nettype wire

// ===== hw/rtl/mat4_vec4_transform.sv =====
// Top level of the 4x4 matrix times 4-vector transform engine.
//
//  channel   dir  handshake                      payload
//  s_axis    in   s_axis_tvalid/s_axis_tready    tdata: x, y, z, w (32 bits each)
//  m_axis    out  m_axis_tvalid/m_axis_tready    tdata: x, y, z, w; tuser: sat flags
//  cfg       in   i_cfg_we (no wait)             i_cfg_idx, i_cfg_wdata (64 bits)
//
//  One vector is accepted per cycle while the skid entry is empty; results pass the four
//  lane stages (multiply, pair add, final add, shift/saturate) and the output register.
//  Reset loads the identity matrix and empties the pipeline.
//  When the output stalls, a skid entry catches one transaction and then the whole
//  pipeline freezes; s_axis_tready comes from a register.
`default_nettype none

module mat4_vec4_transform
    import mvt_pkg::*;
#(
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [127:0]          s_axis_tdata,  // x[31:0], y[63:32], z[95:64], w[127:96]
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [127:0]          m_axis_tdata,  // x[31:0], y[63:32], z[95:64], w[127:96]
    output logic [3:0]            m_axis_tuser,  // sat_flags[3:0]
    input  logic                  i_cfg_we,
    input  t_cfg_idx              i_cfg_idx,
    input  logic [CFG_BITS-1:0]   i_cfg_wdata
);

    localparam logic [63:0] ONE64  = 64'd1 << FRAC_BITS;
    localparam logic [31:0] W_MASK = 32'((64'd1 << WORD_BITS) - 64'd1);
    localparam logic [31:0] ONE_Q  = ONE64[31:0] & W_MASK;
    localparam logic [31:0] MAX32  = 32'((64'd1 << (WORD_BITS - 1)) - 64'd1);
    localparam logic [31:0] MIN32  = 32'(64'd1 << (WORD_BITS - 1));

    logic [CFG_BITS-1:0]                 r_mat [NUM_REGS];
    logic [LANE_STAGES-1:0]              r_vld;
    logic                                w_en;
    logic [NUM_COLS-1:0][WORD_BITS-1:0]  w_vec;
    logic [NUM_LANES-1:0][WORD_BITS-1:0] w_res;
    logic [NUM_LANES-1:0]                w_sat;
    t_result                             w_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_REGS; i++) begin
                case (t_cfg_idx'(i))
                    CFG_ROW0_COLS01, CFG_ROW2_COLS23: r_mat[i] <= {32'd0, ONE_Q};
                    CFG_ROW1_COLS01, CFG_ROW3_COLS23: r_mat[i] <= {ONE_Q, 32'd0};
                    default:                          r_mat[i] <= '0;
                endcase
            end
        end else if (i_cfg_we) begin
            r_mat[i_cfg_idx] <= i_cfg_wdata;
        end
    end

    always_comb begin
        for (int c = 0; c < NUM_COLS; c++) begin
            w_vec[c] = s_axis_tdata[c*FIELD_BITS +: WORD_BITS];
        end
    end

    // advance every stage together unless the skid entry is full
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LANE_STAGES-2:0], s_axis_tvalid};
        end
    end

    for (genvar r = 0; r < NUM_LANES; r++) begin : g_lane
        logic [NUM_COLS-1:0][WORD_BITS-1:0] w_row;

        for (genvar c = 0; c < NUM_COLS; c++) begin : g_col
            assign w_row[c] = r_mat[2*r + c/2][(c%2)*32 +: WORD_BITS];
        end

        mvt_lane #(
            .WORD_BITS (WORD_BITS),
            .FRAC_BITS (FRAC_BITS)
        ) u_lane (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_row (w_row),
            .i_vec (w_vec),
            .o_res (w_res[r]),
            .o_sat (w_sat[r])
        );
    end

    mvt_out #(
        .WORD_BITS (WORD_BITS)
    ) u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_vld[LANE_STAGES-1]),
        .i_res   (w_res),
        .i_sat   (w_sat),
        .o_ready (w_en),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (w_out)
    );

    assign s_axis_tready = w_en;
    assign m_axis_tdata  = w_out.comp;
    assign m_axis_tuser  = w_out.sat;

`ifndef SYNTH
    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |-> m_axis_tvalid)
        else $error("skid entry full while output register empty");

    a_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(r_vld))
        else $error("pipeline advanced while skid entry full");

    a_sat_x: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |->
            (m_axis_tdata[31:0] == MAX32) || (m_axis_tdata[31:0] == MIN32))
        else $error("x flagged saturated but not at a limit");

    a_sat_w: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[3] |->
            (m_axis_tdata[127:96] == MAX32) || (m_axis_tdata[127:96] == MIN32))
        else $error("w flagged saturated but not at a limit");
`endif

endmodule

`default_nettype wire
